@@ src/bprb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprb_pkg
// Shared types for the Pascal row builder: controller states and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package bprb_pkg;

    localparam int unsigned FIELD_W = 6;
    localparam int unsigned COEF_W  = 31;
    localparam int unsigned ENTRY_W = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUILD,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic start;
        logic step;
        logic shift;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic special;
        logic row_done;
        logic shift_done;
    } status_t;

endpackage

@@ src/bprb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprb_ctrl
// Sequencer for one request: builds rows up to n, shifts entry k down to
// the first cell and loads the output register when it is free.
// ----------------------------------------------------------------------------
module bprb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  bprb_pkg::status_t status,
    output bprb_pkg::cmd_t    cmd
);

    bprb_pkg::state_t state_reg;
    bprb_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accept;
    logic             can_load;

    assign s_tready = (state_reg == bprb_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign can_load = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bprb_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = bprb_pkg::ST_BUILD;
                end
            end
            bprb_pkg::ST_BUILD: begin
                if (status.special) begin
                    state_next = bprb_pkg::ST_FINISH;
                end else if (status.row_done) begin
                    state_next = bprb_pkg::ST_SHIFT;
                end
            end
            bprb_pkg::ST_SHIFT: begin
                if (status.shift_done) begin
                    state_next = bprb_pkg::ST_FINISH;
                end
            end
            bprb_pkg::ST_FINISH: begin
                if (can_load) begin
                    state_next = bprb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bprb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd       = '0;
        cmd.start = accept;
        case (state_reg)
            bprb_pkg::ST_BUILD: begin
                cmd.step = !status.special && !status.row_done;
            end
            bprb_pkg::ST_SHIFT: begin
                cmd.shift = !status.shift_done;
            end
            bprb_pkg::ST_FINISH: begin
                cmd.load = can_load;
            end
            default: begin
                cmd.step = 1'b0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bprb_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/bprb_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprb_dp
// Row of saturating cells holding one row of Pascal's triangle, request
// registers, row and shift counters, and the output register.
// ----------------------------------------------------------------------------
module bprb_dp #(
    parameter int unsigned MAX_N = 63
) (
    input  logic                            aclk,
    input  logic [bprb_pkg::FIELD_W-1:0]    n_value,
    input  logic [bprb_pkg::FIELD_W-1:0]    k_value,
    input  bprb_pkg::cmd_t                  cmd,
    output bprb_pkg::status_t               status,
    output logic [bprb_pkg::COEF_W-1:0]     coefficient,
    output logic                            too_large,
    output logic                            k_exceeds_n
);

    localparam int unsigned NCELL = MAX_N + 1;
    localparam int unsigned EW    = bprb_pkg::ENTRY_W;
    localparam int unsigned CW    = bprb_pkg::COEF_W;
    localparam int unsigned FW    = bprb_pkg::FIELD_W;

    logic [EW-1:0] cell_reg  [NCELL];
    logic [EW-1:0] cell_next [NCELL];
    logic [FW-1:0] n_reg;
    logic [FW-1:0] k_reg;
    logic [FW-1:0] row_cnt_reg;
    logic [FW-1:0] row_cnt_next;
    logic [FW-1:0] shift_cnt_reg;
    logic [FW-1:0] shift_cnt_next;
    logic          kex_reg;
    logic          big_reg;
    logic [CW-1:0] coef_reg;
    logic [CW-1:0] coef_next;
    logic          too_large_reg;
    logic          too_large_next;
    logic          kex_out_reg;
    logic          kex_out_next;
    logic          in_kex;
    logic          in_big;

    function automatic logic [EW-1:0] sat_add(input logic [EW-1:0] a, input logic [EW-1:0] b);
        logic [CW:0] sum;
        sum = {1'b0, a[CW-1:0]} + {1'b0, b[CW-1:0]};
        if (a[EW-1] || b[EW-1] || sum[CW]) begin
            return {1'b1, {CW{1'b0}}};
        end
        return {1'b0, sum[CW-1:0]};
    endfunction

    assign in_kex = (k_value > n_value);
    assign in_big = !in_kex && (32'(n_value) > MAX_N);

    assign status.special    = kex_reg || big_reg;
    assign status.row_done   = (row_cnt_reg == n_reg);
    assign status.shift_done = (shift_cnt_reg == k_reg);

    always_comb begin
        for (int i = 0; i < NCELL; i++) begin
            cell_next[i] = cell_reg[i];
        end
        if (cmd.start) begin
            for (int i = 0; i < NCELL; i++) begin
                cell_next[i] = '0;
            end
            cell_next[0] = EW'(1);
        end else if (cmd.step) begin
            cell_next[0] = EW'(1);
            for (int i = 1; i < NCELL; i++) begin
                cell_next[i] = sat_add(cell_reg[i-1], cell_reg[i]);
            end
        end else if (cmd.shift) begin
            for (int i = 0; i < NCELL - 1; i++) begin
                cell_next[i] = cell_reg[i+1];
            end
            cell_next[NCELL-1] = '0;
        end
    end

    always_comb begin
        row_cnt_next   = row_cnt_reg;
        shift_cnt_next = shift_cnt_reg;
        if (cmd.start) begin
            row_cnt_next   = '0;
            shift_cnt_next = '0;
        end else begin
            if (cmd.step) begin
                row_cnt_next = row_cnt_reg + FW'(1);
            end
            if (cmd.shift) begin
                shift_cnt_next = shift_cnt_reg + FW'(1);
            end
        end
    end

    always_comb begin
        coef_next      = coef_reg;
        too_large_next = too_large_reg;
        kex_out_next   = kex_out_reg;
        if (cmd.load) begin
            if (kex_reg || big_reg) begin
                coef_next      = '0;
                too_large_next = big_reg;
                kex_out_next   = kex_reg;
            end else if (cell_reg[0][EW-1]) begin
                coef_next      = '0;
                too_large_next = 1'b1;
                kex_out_next   = 1'b0;
            end else begin
                coef_next      = cell_reg[0][CW-1:0];
                too_large_next = 1'b0;
                kex_out_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NCELL; i++) begin
            cell_reg[i] <= cell_next[i];
        end
        row_cnt_reg   <= row_cnt_next;
        shift_cnt_reg <= shift_cnt_next;
        coef_reg      <= coef_next;
        too_large_reg <= too_large_next;
        kex_out_reg   <= kex_out_next;
        if (cmd.start) begin
            n_reg   <= n_value;
            k_reg   <= k_value;
            kex_reg <= in_kex;
            big_reg <= in_big;
        end
    end

    assign coefficient = coef_reg;
    assign too_large   = too_large_reg;
    assign k_exceeds_n = kex_out_reg;

endmodule

@@ src/binomial_pascal_row_builder_top.sv @@
`timescale 1ns / 1ps
// Operation: one row of the triangle is built per cycle in a row of MAX_N + 1 cells, then entry k
// is shifted down to the first cell and loaded into the output register; requests with k > n
// or n > MAX_N skip the build and shift. A new request is taken only once the previous one is
// loaded; the next input is taken while a result still waits. Reset: synchronous, active-low
// aresetn clears the controller and output valid; the cells are cleared at the start of every
// request and need no reset.
// ----------------------------------------------------------------------------
// binomial_pascal_row_builder_top
// Computes C(n,k) by building Pascal's triangle with saturating cells.
// ----------------------------------------------------------------------------
module binomial_pascal_row_builder_top #(
    parameter int unsigned MAX_N = 63
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // n_value [5:0], k_value [11:6], zeros [15:12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // coefficient [30:0], zero [31]
    output logic [1:0]  m_tuser    // too_large [0], k_exceeds_n [1]
);

    bprb_pkg::cmd_t                   cmd;
    bprb_pkg::status_t                status;
    logic [bprb_pkg::COEF_W-1:0]      coefficient;
    logic                             too_large;
    logic                             k_exceeds_n;

    bprb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bprb_dp #(
        .MAX_N (MAX_N)
    ) u_dp (
        .aclk        (aclk),
        .n_value     (s_tdata[5:0]),
        .k_value     (s_tdata[11:6]),
        .cmd         (cmd),
        .status      (status),
        .coefficient (coefficient),
        .too_large   (too_large),
        .k_exceeds_n (k_exceeds_n)
    );

    assign m_tdata = {1'b0, coefficient};
    assign m_tuser = {k_exceeds_n, too_large};

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Pascal row builder. A directed set covers the
// triangle's edges, the overflow boundary and k above n. Random requests then
// follow, most of them valid and some with k above n. Every accepted request
// is predicted by rebuilding the triangle with saturating 32-bit entries. Each
// result transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [bprb_pkg::ENTRY_W-1:0] OVERFLOW_FLAG = 32'h8000_0000;
    localparam logic [bprb_pkg::ENTRY_W-1:0] VALUE_BITS    = 32'h7FFF_FFFF;
    localparam int                           RANDOM_ITEMS  = 1900;

    typedef struct packed {
        logic [bprb_pkg::COEF_W-1:0] coefficient;
        logic                        too_large;
        logic                        k_exceeds_n;
    } binom_result_t;

    class binom_scoreboard;
        binom_result_t pending_coefs[$];
        int            errors;
        int            checked;
        int            k_above_n_seen;
        int            overflow_seen;

        function new();
            errors         = 0;
            checked        = 0;
            k_above_n_seen = 0;
            overflow_seen  = 0;
        endfunction

        // The triangle is rebuilt in one row of saturating entries for every request with k at most n.
        function void note_input(logic [bprb_pkg::FIELD_W-1:0] n,
                                 logic [bprb_pkg::FIELD_W-1:0] k);
            logic [bprb_pkg::ENTRY_W-1:0] cells [64];
            logic [bprb_pkg::ENTRY_W-1:0] sum;
            binom_result_t                res;
            res = '0;
            if (k > n) begin
                res.k_exceeds_n = 1'b1;
            end else begin
                cells[0] = 32'd1;
                for (int r = 1; r <= int'(n); r++) begin
                    cells[r] = 32'd1;
                    for (int i = r - 1; i >= 1; i--) begin
                        if (((cells[i-1] | cells[i]) & OVERFLOW_FLAG) != 0) begin
                            sum = OVERFLOW_FLAG;
                        end else begin
                            sum = (cells[i-1] & VALUE_BITS) + (cells[i] & VALUE_BITS);
                            if (sum > VALUE_BITS) sum = OVERFLOW_FLAG;
                        end
                        cells[i] = sum;
                    end
                end
                if ((cells[k] & OVERFLOW_FLAG) != 0) begin
                    res.too_large = 1'b1;
                end else begin
                    res.coefficient = cells[k][bprb_pkg::COEF_W-1:0];
                end
            end
            pending_coefs.insert(pending_coefs.size(), res);
        endfunction

        function void check_result(logic [31:0] tdata, logic [1:0] tuser);
            binom_result_t want;
            if (pending_coefs.size() == 0) begin
                $error("Result transfer with no request outstanding: tdata %h tuser %b",
                       tdata, tuser);
                errors++;
                return;
            end
            want = pending_coefs.pop_front();
            checked++;
            if (want.k_exceeds_n) k_above_n_seen++;
            if (want.too_large) overflow_seen++;
            if (tdata[bprb_pkg::COEF_W-1:0] !== want.coefficient) begin
                $error("coefficient: expected %0d, got %0d", want.coefficient,
                       tdata[bprb_pkg::COEF_W-1:0]);
                errors++;
            end
            if (tdata[31] !== 1'b0) begin
                $error("tdata pad bit: expected 0, got %b", tdata[31]);
                errors++;
            end
            if (tuser[0] !== want.too_large) begin
                $error("too_large: expected %b, got %b", want.too_large, tuser[0]);
                errors++;
            end
            if (tuser[1] !== want.k_exceeds_n) begin
                $error("k_exceeds_n: expected %b, got %b", want.k_exceeds_n, tuser[1]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    binom_scoreboard sb = new();
    int              burst_left = 0;
    int              ready_hold = 0;

    binomial_pascal_row_builder_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The receiver alternates ready and stalled stretches of random length.
    always @(posedge aclk) begin
        if (ready_hold == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(1, 40);
            end else begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(1, 24);
            end
        end else begin
            ready_hold <= ready_hold - 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    // The sender works in bursts; valid stays high between transfers of one burst.
    task automatic send_request(input logic [bprb_pkg::FIELD_W-1:0] n,
                                input logic [bprb_pkg::FIELD_W-1:0] k);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, k, n};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(n, k);
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end else begin
            burst_left--;
        end
    endtask

    initial begin
        logic [bprb_pkg::FIELD_W-1:0] n;
        logic [bprb_pkg::FIELD_W-1:0] k;
        int                           pick;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Edges, the largest row, the 2^31 boundary and k above n.
        send_request(6'd0, 6'd0);
        send_request(6'd1, 6'd0);
        send_request(6'd1, 6'd1);
        send_request(6'd2, 6'd1);
        send_request(6'd63, 6'd0);
        send_request(6'd63, 6'd63);
        send_request(6'd63, 6'd1);
        send_request(6'd63, 6'd62);
        send_request(6'd63, 6'd31);
        send_request(6'd63, 6'd32);
        send_request(6'd33, 6'd16);
        send_request(6'd33, 6'd17);
        send_request(6'd34, 6'd16);
        send_request(6'd34, 6'd17);
        send_request(6'd34, 6'd15);
        send_request(6'd40, 6'd9);
        send_request(6'd40, 6'd10);
        send_request(6'd0, 6'd63);
        send_request(6'd0, 6'd1);
        send_request(6'd5, 6'd6);
        send_request(6'd62, 6'd63);
        send_request(6'd21, 6'd42);

        for (int item = 0; item < RANDOM_ITEMS; item++) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                n = 6'($urandom_range(0, 63));
                k = 6'($urandom_range(0, n));
            end else if (pick < 80) begin
                n = 6'($urandom_range(30, 63));
                k = 6'((n >> 1) - 3 + $urandom_range(0, 6));
            end else if (pick < 95) begin
                n = 6'($urandom_range(0, 62));
                k = 6'($urandom_range(n + 1, 63));
            end else begin
                n = 6'($urandom);
                k = 6'($urandom);
            end
            send_request(n, k);
        end
        s_tvalid <= 1'b0;

        while (sb.pending_coefs.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);

        $display("Checked %0d coefficients: %0d with k above n, %0d beyond 31 bits.",
                 sb.checked, sb.k_above_n_seen, sb.overflow_seen);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("Timeout with %0d results outstanding.", sb.pending_coefs.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
